// ===== hdl/cme_pkg.sv =====
// shared types, codes and character constants of the card machine executor
`default_nettype none

package cme_pkg;

  // stream widths
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned LIMIT_W     = 14;

  localparam logic [LIMIT_W-1:0] LIMIT_MAX = 14'h3FFF;

  // item functions
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_STEP  = 2'd2;

  // result kinds
  localparam logic [2:0] KIND_DONE   = 3'd0;
  localparam logic [2:0] KIND_CARD   = 3'd1;
  localparam logic [2:0] KIND_PRINT  = 3'd2;
  localparam logic [2:0] KIND_HALT   = 3'd3;
  localparam logic [2:0] KIND_TIME   = 3'd4;
  localparam logic [2:0] KIND_LINE   = 3'd5;
  localparam logic [2:0] KIND_OPERR  = 3'd6;
  localparam logic [2:0] KIND_HALTED = 3'd7;

  // configuration register indexes
  localparam logic CFG_TIME_LIMIT = 1'b0;
  localparam logic CFG_LINE_LIMIT = 1'b1;

  // characters
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [31:0] DASHES  = {4{CH_DASH}};

  typedef enum logic [2:0] {
    OP_H,
    OP_GD,
    OP_PD,
    OP_LR,
    OP_SR,
    OP_CR,
    OP_BT,
    OP_BAD
  } op_e;

  // controller to datapath
  typedef struct packed {
    logic       accept;
    logic       opnd_load;
    logic       clear_job;
    logic       mem_wr_in;
    logic       sr_write;
    logic       set_halt;
    logic       ic_inc;
    logic       ic_jump;
    logic       time_inc;
    logic       line_inc;
    logic       r_load;
    logic       ct_load;
    logic       rd_opnd;
    logic       rd_print;
    logic       pidx_clr;
    logic       pidx_inc;
    logic       res_load;
    logic [2:0] res_kind;
    logic       res_card;
    logic       out_single;
    logic       out_saved;
    logic       out_print;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] func;
    logic       halted;
    logic       time_hit;
    logic       time_hit_next;
    logic       line_over_next;
    logic       ic_oob;
    op_e        op;
    logic       opnd_ok;
    logic       ctog;
    logic       out_free;
    logic       print_last;
  } status_t;

endpackage

`default_nettype wire

// ===== hdl/cme_dp.sv =====
// datapath: word memory, machine registers, counters and output register
`default_nettype none

module cme_dp
  import cme_pkg::*;
#(
  parameter int unsigned MEM_WORDS  = 128,
  parameter int unsigned LINE_WORDS = 10
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [LIMIT_W-1:0] cfg_data_i,
  input  wire logic [1:0]         in_func_i,
  input  wire logic [6:0]         in_addr_i,
  input  wire logic [31:0]        in_word_i,
  input  wire cmd_t               cmd_i,
  input  wire logic               out_ready_i,
  output status_t                 status_o,
  output logic                    out_valid_o,
  output logic [2:0]              out_kind_o,
  output logic [31:0]             out_word_o,
  output logic [6:0]              out_ca_o,
  output logic                    out_last_o
);

  localparam int unsigned RAW = $clog2(MEM_WORDS + 1);
  localparam int unsigned AW  = $clog2(MEM_WORDS);
  localparam int unsigned PIW = $clog2(LINE_WORDS + 1);

  function automatic logic [31:0] dash_to_space(input logic [31:0] w);
    logic [31:0] r;
    r = w;
    for (int b = 0; b < 4; b++) begin
      if (w[8*b +: 8] == CH_DASH) r[8*b +: 8] = CH_SPACE;
    end
    return r;
  endfunction

  // latched item
  logic [1:0]  func_q;
  logic [6:0]  addr_q;
  logic [31:0] word_q;

  logic [LIMIT_W-1:0] time_limit_q, line_limit_q;
  logic [LIMIT_W-1:0] time_count_q, line_count_q;
  logic [LIMIT_W-1:0] line_next;
  logic [31:0]        r_q;
  logic               ctog_q;
  logic [RAW-1:0]     ic_q;
  logic               halted_q;
  logic [6:0]         opnd_q, opnd_d;
  logic [PIW-1:0]     pidx_q;
  logic [2:0]         res_kind_q;
  logic [6:0]         res_ca_q;

  // word memory with per-entry valid bits, unwritten entries read as dashes
  logic [31:0]          mem [MEM_WORDS];
  logic [MEM_WORDS-1:0] valid_q;
  logic [31:0]          mem_q;
  logic                 rd_hit_q;
  logic [31:0]          rd_word;

  logic           rd_en, rd_in_range;
  logic [RAW-1:0] rd_addr;
  logic           wr_en;
  logic [RAW-1:0] wr_addr;
  logic [31:0]    wr_data;
  logic           in_addr_ok;

  logic [7:0] c0, c1, c2, c3;
  logic       d2_ok, d3_ok;
  op_e        op;

  logic       out_valid_q, out_last_q;
  logic [2:0] out_kind_q;
  logic [31:0] out_word_q;
  logic [6:0] out_ca_q;
  logic       out_free;

  assign rd_word = rd_hit_q ? mem_q : DASHES;
  assign c0 = rd_word[31:24];
  assign c1 = rd_word[23:16];
  assign c2 = rd_word[15:8];
  assign c3 = rd_word[7:0];
  assign d2_ok = (c2 >= CH_ZERO) && (c2 <= CH_NINE);
  assign d3_ok = (c3 >= CH_ZERO) && (c3 <= CH_NINE);
  // 10 * d2 + d3 as shifts and adds
  assign opnd_d = (7'(c2[3:0]) << 3) + (7'(c2[3:0]) << 1) + 7'(c3[3:0]);

  always_comb begin
    if (c0 == CH_H)                      op = OP_H;
    else if (c0 == CH_G && c1 == CH_D)   op = OP_GD;
    else if (c0 == CH_P && c1 == CH_D)   op = OP_PD;
    else if (c0 == CH_L && c1 == CH_R)   op = OP_LR;
    else if (c0 == CH_S && c1 == CH_R)   op = OP_SR;
    else if (c0 == CH_C && c1 == CH_R)   op = OP_CR;
    else if (c0 == CH_B && c1 == CH_T)   op = OP_BT;
    else                                 op = OP_BAD;
  end

  // memory ports
  always_comb begin
    rd_en   = cmd_i.accept | cmd_i.rd_opnd | cmd_i.rd_print;
    rd_addr = ic_q;
    if (cmd_i.rd_opnd)       rd_addr = RAW'(opnd_d);
    else if (cmd_i.rd_print) rd_addr = RAW'(opnd_q) + RAW'(pidx_q);
  end
  assign rd_in_range = rd_addr < RAW'(MEM_WORDS);

  assign in_addr_ok = RAW'(addr_q) < RAW'(MEM_WORDS);
  assign wr_en      = (cmd_i.mem_wr_in & in_addr_ok) | cmd_i.sr_write;
  assign wr_addr    = cmd_i.mem_wr_in ? RAW'(addr_q) : RAW'(opnd_d);
  assign wr_data    = cmd_i.mem_wr_in ? word_q : r_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr[AW-1:0]] <= wr_data;
    if (rd_en && rd_in_range) mem_q <= mem[rd_addr[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_hit_q <= 1'b0;
    end else begin
      if (cmd_i.clear_job) valid_q <= '0;
      else if (wr_en)      valid_q[wr_addr[AW-1:0]] <= 1'b1;
      if (rd_en) rd_hit_q <= rd_in_range && valid_q[rd_addr[AW-1:0]];
    end
  end

  // item latch and operand, payload only
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q <= in_func_i;
      addr_q <= in_addr_i;
      word_q <= in_word_i;
    end
    if (cmd_i.opnd_load) opnd_q <= opnd_d;
    if (cmd_i.res_load) begin
      res_kind_q <= cmd_i.res_kind;
      res_ca_q   <= cmd_i.res_card ? opnd_d : 7'd0;
    end
  end

  assign line_next = (line_count_q == LIMIT_MAX) ? line_count_q : line_count_q + 1'b1;

  // configuration and machine state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_limit_q <= '0;
      line_limit_q <= '0;
      time_count_q <= '0;
      line_count_q <= '0;
      r_q          <= '0;
      ctog_q       <= 1'b0;
      ic_q         <= '0;
      halted_q     <= 1'b0;
      pidx_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TIME_LIMIT: time_limit_q <= cfg_data_i;
          CFG_LINE_LIMIT: line_limit_q <= cfg_data_i;
        endcase
      end
      if (cmd_i.clear_job) begin
        time_count_q <= '0;
        line_count_q <= '0;
        r_q          <= '0;
        ctog_q       <= 1'b0;
        ic_q         <= '0;
        halted_q     <= 1'b0;
      end else begin
        if (cmd_i.time_inc) time_count_q <= time_count_q + 1'b1;
        if (cmd_i.line_inc) line_count_q <= line_next;
        if (cmd_i.r_load)   r_q <= rd_word;
        if (cmd_i.ct_load)  ctog_q <= (r_q == rd_word);
        if (cmd_i.ic_jump)     ic_q <= RAW'(opnd_d);
        else if (cmd_i.ic_inc) ic_q <= ic_q + 1'b1;
        if (cmd_i.set_halt) halted_q <= 1'b1;
      end
      if (cmd_i.pidx_clr)      pidx_q <= '0;
      else if (cmd_i.pidx_inc) pidx_q <= pidx_q + 1'b1;
    end
  end

  // output register
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_single || cmd_i.out_saved || cmd_i.out_print) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_single) begin
      out_kind_q <= cmd_i.res_kind;
      out_word_q <= '0;
      out_ca_q   <= cmd_i.res_card ? opnd_d : 7'd0;
      out_last_q <= 1'b1;
    end else if (cmd_i.out_saved) begin
      out_kind_q <= res_kind_q;
      out_word_q <= '0;
      out_ca_q   <= res_ca_q;
      out_last_q <= 1'b1;
    end else if (cmd_i.out_print) begin
      out_kind_q <= KIND_PRINT;
      out_word_q <= dash_to_space(rd_word);
      out_ca_q   <= 7'd0;
      out_last_q <= pidx_q == PIW'(LINE_WORDS - 1);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_word_o  = out_word_q;
  assign out_ca_o    = out_ca_q;
  assign out_last_o  = out_last_q;

  always_comb begin
    status_o.func           = func_q;
    status_o.halted         = halted_q;
    status_o.time_hit       = time_count_q >= time_limit_q;
    status_o.time_hit_next  = ({1'b0, time_count_q} + 1'b1) >= {1'b0, time_limit_q};
    status_o.line_over_next = line_next > line_limit_q;
    status_o.ic_oob         = ic_q >= RAW'(MEM_WORDS);
    status_o.op             = op;
    status_o.opnd_ok        = d2_ok && d3_ok;
    status_o.ctog           = ctog_q;
    status_o.out_free       = out_free;
    status_o.print_last     = pidx_q == PIW'(LINE_WORDS - 1);
  end

endmodule

`default_nettype wire

// ===== hdl/cme_ctrl.sv =====
// controller: item sequencing and instruction decode decisions
`default_nettype none

module cme_ctrl
  import cme_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_LOAD   = 3'd2;
  localparam logic [2:0] S_COMP   = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;
  localparam logic [2:0] S_PRD    = 3'd5;
  localparam logic [2:0] S_PWR    = 3'd6;

  logic [2:0] state_q, state_d;
  logic       single;
  logic [2:0] kind;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    single  = 1'b0;
    kind    = KIND_DONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.opnd_load = 1'b1;
        single          = 1'b1;
        case (status_i.func)
          FUNC_START: cmd_o.clear_job = 1'b1;
          FUNC_WRITE: cmd_o.mem_wr_in = 1'b1;
          FUNC_STEP: begin
            if (status_i.halted) begin
              kind = KIND_HALTED;
            end else if (status_i.time_hit) begin
              cmd_o.set_halt = 1'b1;
              kind           = KIND_TIME;
            end else if (status_i.ic_oob) begin
              cmd_o.set_halt = 1'b1;
              kind           = KIND_OPERR;
            end else if (status_i.op == OP_H) begin
              cmd_o.ic_inc   = 1'b1;
              cmd_o.set_halt = 1'b1;
              kind           = KIND_HALT;
            end else if (status_i.op == OP_BAD || !status_i.opnd_ok) begin
              cmd_o.set_halt = 1'b1;
              kind           = KIND_OPERR;
            end else begin
              cmd_o.time_inc = 1'b1;
              unique case (status_i.op)
                OP_BT: begin
                  cmd_o.ic_jump = status_i.ctog;
                  cmd_o.ic_inc  = !status_i.ctog;
                end
                OP_GD: begin
                  cmd_o.ic_inc = 1'b1;
                  if (status_i.time_hit_next) begin
                    cmd_o.set_halt = 1'b1;
                    kind           = KIND_TIME;
                  end else begin
                    kind           = KIND_CARD;
                    cmd_o.res_card = 1'b1;
                  end
                end
                OP_PD: begin
                  cmd_o.ic_inc = 1'b1;
                  if (status_i.time_hit_next) begin
                    cmd_o.set_halt = 1'b1;
                    kind           = KIND_TIME;
                  end else begin
                    cmd_o.line_inc = 1'b1;
                    if (status_i.line_over_next) begin
                      cmd_o.set_halt = 1'b1;
                      kind           = KIND_LINE;
                    end else begin
                      single         = 1'b0;
                      cmd_o.pidx_clr = 1'b1;
                      state_d        = S_PRD;
                    end
                  end
                end
                OP_LR: begin
                  cmd_o.ic_inc  = 1'b1;
                  cmd_o.rd_opnd = 1'b1;
                  single        = 1'b0;
                  state_d       = S_LOAD;
                end
                OP_CR: begin
                  cmd_o.ic_inc  = 1'b1;
                  cmd_o.rd_opnd = 1'b1;
                  single        = 1'b0;
                  state_d       = S_COMP;
                end
                OP_SR: begin
                  cmd_o.ic_inc   = 1'b1;
                  cmd_o.sr_write = 1'b1;
                end
                default: ;
              endcase
            end
          end
          default: ;
        endcase
      end
      S_LOAD: begin
        cmd_o.r_load = 1'b1;
        single       = 1'b1;
      end
      S_COMP: begin
        cmd_o.ct_load = 1'b1;
        single        = 1'b1;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.out_saved = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_PRD: begin
        cmd_o.rd_print = 1'b1;
        state_d        = S_PWR;
      end
      S_PWR: begin
        if (status_i.out_free) begin
          cmd_o.out_print = 1'b1;
          if (status_i.print_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.pidx_inc = 1'b1;
            state_d        = S_PRD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    // single result: straight to the output register, or park it
    if (single) begin
      cmd_o.res_kind = kind;
      cmd_o.res_load = 1'b1;
      if (status_i.out_free) begin
        cmd_o.out_single = 1'b1;
        state_d          = S_IDLE;
      end else begin
        state_d = S_EMIT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/card_machine_executor_unit.sv =====
// top level of the card machine executor
//
// Input stream (s_axis): tuser carries the function (start job, write word,
// step), tdata the word address and the four-character word. Output stream
// (m_axis): tuser carries the result kind, tdata the print word and the card
// address, tlast marks the final result of an item. Configuration writes of
// the time and line limits go through cfg_we_i/cfg_idx_i/cfg_data_i.
// One item is worked on at a time; s_axis_tready is high only while idle.
// Start job, write word and most steps are latched on acceptance and decoded
// in the decode state, which loads the result; LR and CR first go through a
// load or compare state, because the operand word needs a second pass through
// the registered memory read port. A PD step then does one read and one
// output load per word. Reset clears the machine state and the limits; all
// memory words read as dashes through per-word valid bits, which start job clears.
// A stalled receiver holds the result in the output register; the block
// accepts the next item meanwhile but loads no new result until it drains.
`default_nettype none

module card_machine_executor_unit
  import cme_pkg::*;
#(
  parameter int unsigned MEM_WORDS  = 128,
  parameter int unsigned LINE_WORDS = 10
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic                   cfg_idx_i,
  input  wire logic [LIMIT_W-1:0]     cfg_data_i,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // address[6:0], word[38:7], zero pad
  input  wire logic [1:0]             s_axis_tuser,  // func[1:0]
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // out_word[31:0], card_address[38:32], pad
  output logic [2:0]                  m_axis_tuser,  // kind[2:0]
  output logic                        m_axis_tlast
);

  cmd_t        cmd;
  status_t     status;
  logic [31:0] out_word;
  logic [6:0]  out_ca;

  cme_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cme_dp #(
    .MEM_WORDS  (MEM_WORDS),
    .LINE_WORDS (LINE_WORDS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_func_i   (s_axis_tuser),
    .in_addr_i   (s_axis_tdata[6:0]),
    .in_word_i   (s_axis_tdata[38:7]),
    .cmd_i       (cmd),
    .out_ready_i (m_axis_tready),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_kind_o  (m_axis_tuser),
    .out_word_o  (out_word),
    .out_ca_o    (out_ca),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_ca, out_word};

endmodule

`default_nettype wire

// ===== hdl/cme_checker.sv =====
// port-level checker of the card machine executor and its bind
`default_nettype none

module cme_checker
  import cme_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic [2:0]             m_axis_tuser,
  input wire logic                   m_axis_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
      $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // only print words come in runs
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == KIND_PRINT)
    else $error("non-final result that is not a print word");

  a_card_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KIND_CARD |-> m_axis_tdata[38:32] == 7'd0)
    else $error("card address set on a non-card result");

  a_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KIND_PRINT |-> m_axis_tdata[31:0] == 32'd0)
    else $error("print word set on a non-print result");

  // one item at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken on back-to-back cycles");

endmodule

bind card_machine_executor_unit cme_checker u_cme_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== verif/tb_top.sv =====
// self-checking testbench of the card machine executor, with a shadow machine predicting every result
`timescale 1ns / 100ps

module tb_top;
  import cme_pkg::*;

  localparam int MEM_WORDS      = 128;
  localparam int LINE_WORDS     = 10;
  localparam int RANDOM_ITEMS   = 200;
  localparam int HOLD_CYCLES    = 300;
  localparam int QUIET_LIMIT    = 5000;
  localparam int SETTLE_CYCLES  = 8;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] word;
    logic [6:0]  card;
    logic        last;
  } result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic                   cfg_idx_i = 1'b0;
  logic [LIMIT_W-1:0]     cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // address[6:0], word[38:7], zero pad
  logic [1:0]             s_axis_tuser = '0;   // func[1:0]
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // out_word[31:0], card_address[38:32], pad
  logic [2:0]             m_axis_tuser;        // kind[2:0]
  logic                   m_axis_tlast;

  card_machine_executor_unit #(
    .MEM_WORDS  (MEM_WORDS),
    .LINE_WORDS (LINE_WORDS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  // shadow machine
  logic [31:0]        mem_img [MEM_WORDS];
  logic [31:0]        reg_gr;
  logic               cmp_tog;
  int                 ic_cnt;
  int                 time_used;
  int                 lines_used;
  logic               job_halted;
  int                 lim_time;
  int                 lim_line;
  logic               card_pending;
  int                 card_at;
  result_t            awaited_q[$];

  int   errors = 0;
  int   items_fed = 0;
  int   quiet_cycles = 0;
  logic no_idle = 1'b0;
  logic hold_ask = 1'b0;

  function automatic void clear_job_image();
    for (int i = 0; i < MEM_WORDS; i++) mem_img[i] = DASHES;
    reg_gr = '0;
    cmp_tog = 1'b0;
    ic_cnt = 0;
    time_used = 0;
    lines_used = 0;
    job_halted = 1'b0;
    card_pending = 1'b0;
  endfunction

  function automatic void post_result(input logic [2:0] kind, input logic [31:0] word,
                                      input logic [6:0] card, input logic last);
    result_t r;
    r.kind = kind;
    r.word = word;
    r.card = card;
    r.last = last;
    awaited_q.push_back(r);
  endfunction

  function automatic void stop_job(input logic [2:0] kind);
    job_halted = 1'b1;
    post_result(kind, '0, '0, 1'b1);
  endfunction

  function automatic logic [31:0] dashes_to_spaces(input logic [31:0] w);
    logic [31:0] r;
    r = w;
    for (int b = 0; b < 4; b++) begin
      if (w[8*b +: 8] == CH_DASH) r[8*b +: 8] = CH_SPACE;
    end
    return r;
  endfunction

  function automatic op_e decode_op(input logic [31:0] ir);
    logic [15:0] mn;
    mn = ir[31:16];
    if (ir[31:24] == CH_H) return OP_H;
    if (mn == {CH_G, CH_D}) return OP_GD;
    if (mn == {CH_P, CH_D}) return OP_PD;
    if (mn == {CH_L, CH_R}) return OP_LR;
    if (mn == {CH_S, CH_R}) return OP_SR;
    if (mn == {CH_C, CH_R}) return OP_CR;
    if (mn == {CH_B, CH_T}) return OP_BT;
    return OP_BAD;
  endfunction

  // one step of the shadow machine
  function automatic void step_machine();
    logic [31:0] ir;
    logic [7:0]  c2;
    logic [7:0]  c3;
    logic [31:0] pw;
    op_e         op;
    int          opnd;
    if (job_halted) begin
      post_result(KIND_HALTED, '0, '0, 1'b1);
    end else if (time_used >= lim_time) begin
      stop_job(KIND_TIME);
    end else if (ic_cnt >= MEM_WORDS) begin
      stop_job(KIND_OPERR);
    end else begin
      ir = mem_img[ic_cnt];
      op = decode_op(ir);
      c2 = ir[15:8];
      c3 = ir[7:0];
      if (op == OP_H) begin
        ic_cnt++;
        stop_job(KIND_HALT);
      end else if (op == OP_BAD || c2 < CH_ZERO || c2 > CH_NINE ||
                   c3 < CH_ZERO || c3 > CH_NINE) begin
        stop_job(KIND_OPERR);
      end else begin
        opnd = int'(c2 - CH_ZERO) * 10 + int'(c3 - CH_ZERO);
        time_used++;
        if (op == OP_BT) begin
          ic_cnt = cmp_tog ? opnd : ic_cnt + 1;
          post_result(KIND_DONE, '0, '0, 1'b1);
        end else begin
          ic_cnt++;
          case (op)
            OP_GD: begin
              if (time_used >= lim_time) begin
                stop_job(KIND_TIME);
              end else begin
                card_pending = 1'b1;
                card_at = opnd;
                post_result(KIND_CARD, '0, 7'(opnd), 1'b1);
              end
            end
            OP_PD: begin
              if (time_used >= lim_time) begin
                stop_job(KIND_TIME);
              end else begin
                if (lines_used < int'(LIMIT_MAX)) lines_used++;
                if (lines_used > lim_line) begin
                  stop_job(KIND_LINE);
                end else begin
                  for (int i = 0; i < LINE_WORDS; i++) begin
                    pw = (opnd + i < MEM_WORDS) ? mem_img[opnd + i] : DASHES;
                    post_result(KIND_PRINT, dashes_to_spaces(pw), '0, i == LINE_WORDS - 1);
                  end
                end
              end
            end
            OP_LR: begin
              reg_gr = mem_img[opnd];
              post_result(KIND_DONE, '0, '0, 1'b1);
            end
            OP_SR: begin
              mem_img[opnd] = reg_gr;
              post_result(KIND_DONE, '0, '0, 1'b1);
            end
            default: begin
              cmp_tog = (reg_gr == mem_img[opnd]);
              post_result(KIND_DONE, '0, '0, 1'b1);
            end
          endcase
        end
      end
    end
  endfunction

  function automatic void execute_item(input logic [1:0] f, input logic [6:0] a,
                                       input logic [31:0] w);
    case (f)
      FUNC_START: begin
        clear_job_image();
        post_result(KIND_DONE, '0, '0, 1'b1);
      end
      FUNC_WRITE: begin
        if (int'(a) < MEM_WORDS) mem_img[a] = w;
        post_result(KIND_DONE, '0, '0, 1'b1);
      end
      FUNC_STEP: step_machine();
      default: post_result(KIND_DONE, '0, '0, 1'b1);
    endcase
  endfunction

  function automatic logic [31:0] instr_word(input logic [7:0] m0, input logic [7:0] m1,
                                             input int n);
    return {m0, m1, CH_ZERO + 8'(n / 10), CH_ZERO + 8'(n % 10)};
  endfunction

  // mostly well-formed instructions, some garbage
  function automatic logic [31:0] gen_instr(input int span);
    int r;
    int n;
    r = $urandom_range(99);
    n = ($urandom_range(3) == 0) ? $urandom_range(99) : $urandom_range(39, 20);
    if (r < 10) return {CH_H, 24'($urandom)};
    if (r < 24) return instr_word(CH_G, CH_D, n);
    if (r < 40) return instr_word(CH_P, CH_D, ($urandom_range(7) == 0) ? $urandom_range(99, 90) : n);
    if (r < 54) return instr_word(CH_L, CH_R, n);
    if (r < 66) return instr_word(CH_S, CH_R, n);
    if (r < 78) return instr_word(CH_C, CH_R, n);
    if (r < 90) return instr_word(CH_B, CH_T, $urandom_range(span - 1));
    if (r < 95) return $urandom;
    return {CH_P, CH_D, CH_DASH, 8'($urandom_range(255))};
  endfunction

  // sender: one transaction, random gaps before it
  task automatic send_item(input logic [1:0] f, input logic [6:0] a, input logic [31:0] w);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < 30) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= {1'b0, w, a};
    do @(posedge clk_i); while (!s_axis_tready);
    execute_item(f, a, w);
    if (f != FUNC_SPARE) items_fed++;
  endtask

  task automatic write_word(input int a, input logic [31:0] w);
    send_item(FUNC_WRITE, 7'(a), w);
  endtask

  task automatic step_once();
    send_item(FUNC_STEP, 7'($urandom), $urandom);
  endtask

  // wait until every awaited result is out and the block is idle
  task automatic settle_block();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (awaited_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_limit(input logic idx, input int val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= LIMIT_W'(val);
    if (idx == CFG_TIME_LIMIT) lim_time = val & int'(LIMIT_MAX);
    else lim_line = val & int'(LIMIT_MAX);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_limits(input int t, input int l);
    settle_block();
    set_limit(CFG_TIME_LIMIT, t);
    set_limit(CFG_LINE_LIMIT, l);
  endtask

  task automatic one_word_job(input logic [31:0] w);
    send_item(FUNC_START, '0, '0);
    write_word(0, w);
    step_once();
  endtask

  // random job: program, data, steps with card service until halted, up to 48 steps
  task automatic run_job();
    int span;
    int n;
    if ($urandom_range(99) >= 15) send_item(FUNC_START, 7'($urandom), $urandom);
    span = $urandom_range(16, 3);
    for (int i = 0; i < span; i++) write_word(i, gen_instr(span));
    n = $urandom_range(4);
    for (int i = 0; i < n; i++) begin
      write_word(($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(39, 20),
                 ($urandom_range(1) == 0) ? $urandom : DASHES);
    end
    for (int s = 0; s < 48 && !job_halted; s++) begin
      step_once();
      if (card_pending) begin
        n = $urandom_range(4, 1);
        for (int k = 0; k < n; k++) begin
          write_word(card_at + k, ($urandom_range(1) == 0) ? gen_instr(span) : $urandom);
        end
        card_pending = 1'b0;
      end
      if ($urandom_range(99) < 4) send_item(FUNC_SPARE, 7'($urandom), $urandom);
    end
    n = $urandom_range(2);
    for (int i = 0; i < n; i++) step_once();
  endtask

  task automatic test_reset_state();
    step_once();                        // both limits are zero after reset
    step_once();
    send_item(FUNC_SPARE, 7'h7F, 32'hFFFF_FFFF);
    send_item(FUNC_START, '0, '0);
    set_limits(9999, 9999);
    step_once();                        // memory reads dashes: not an opcode
  endtask

  task automatic test_instructions();
    logic [31:0] prog [12];
    prog = '{instr_word(CH_L, CH_R, 30), instr_word(CH_C, CH_R, 31),
             instr_word(CH_B, CH_T, 4), {CH_H, CH_DASH, CH_DASH, CH_DASH},
             instr_word(CH_S, CH_R, 32), instr_word(CH_L, CH_R, 40),
             instr_word(CH_C, CH_R, 42), instr_word(CH_B, CH_T, 0),
             instr_word(CH_G, CH_D, 50), instr_word(CH_P, CH_D, 48),
             instr_word(CH_P, CH_D, 99), {CH_H, CH_ZERO, CH_ZERO, CH_ZERO}};
    send_item(FUNC_START, '0, '0);
    for (int i = 0; i < 12; i++) write_word(i, prog[i]);
    write_word(40, 32'hFFFF_FFFF);
    write_word(42, 32'h0000_0000);
    while (!job_halted) begin
      step_once();
      if (card_pending) begin
        write_word(card_at, {8'h41, CH_DASH, 8'h42, CH_DASH});
        write_word(card_at + 1, 32'hFFFF_FFFF);
        card_pending = 1'b0;
      end
    end
    step_once();
  endtask

  task automatic test_faults();
    set_limits(9999, 0);
    one_word_job({CH_G, CH_D, 8'h41, CH_ZERO + 8'd1});
    one_word_job({8'h58, 8'h59, CH_ZERO + 8'd1, CH_ZERO + 8'd2});
    one_word_job({CH_P, CH_D, CH_ZERO + 8'd5, CH_NINE + 8'd1});
    one_word_job({CH_L, CH_R, CH_ZERO - 8'd1, CH_ZERO});
    one_word_job(instr_word(CH_P, CH_D, 0));        // line limit of zero
    set_limits(1, 9999);
    one_word_job(instr_word(CH_G, CH_D, 10));       // time runs out inside GD
    one_word_job(instr_word(CH_L, CH_R, 0));
    step_once();                                    // time runs out before fetch
  endtask

  // walk the counter off the end of memory
  task automatic test_counter_overrun();
    logic [7:0] m0;
    set_limits(9999, 9999);
    send_item(FUNC_START, '0, '0);
    write_word(0, instr_word(CH_C, CH_R, 98));
    write_word(1, instr_word(CH_B, CH_T, 99));
    write_word(98, 32'h0);
    for (int a = 99; a < MEM_WORDS; a++) begin
      case ($urandom_range(2))
        0: m0 = CH_L;
        1: m0 = CH_S;
        default: m0 = CH_C;
      endcase
      write_word(a, instr_word(m0, CH_R, $urandom_range(97)));
    end
    while (!job_halted) step_once();
    step_once();
  endtask

  task automatic test_full_rate();
    set_limits(60, 9999);
    no_idle = 1'b1;
    repeat (2) run_job();
    no_idle = 1'b0;
  endtask

  // receiver stalls long while prints pile up at the input
  task automatic test_output_stall();
    set_limits(9999, 9999);
    hold_ask = 1'b1;
    send_item(FUNC_START, '0, '0);
    for (int i = 0; i < 4; i++) write_word(i, instr_word(CH_P, CH_D, 20 + 10 * i));
    write_word(4, {CH_H, CH_DASH, CH_DASH, CH_DASH});
    for (int i = 0; i < 6; i++) step_once();
  endtask

  task automatic test_random_jobs();
    int base;
    int r;
    int t;
    int l;
    base = items_fed;
    while (items_fed - base < RANDOM_ITEMS) begin
      r = $urandom_range(99);
      if (r < 5) t = 0;
      else if (r < 70) t = $urandom_range(40, 1);
      else if (r < 88) t = $urandom_range(200, 41);
      else if (r < 96) t = 9999;
      else t = int'(LIMIT_MAX);
      r = $urandom_range(99);
      if (r < 10) l = 0;
      else if (r < 80) l = $urandom_range(4, 1);
      else l = 9999;
      set_limits(t, l);
      run_job();
    end
  endtask

  // receiver
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_ask) begin
        hold_ask = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      m_axis_tready <= no_idle || ($urandom_range(99) >= 30);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_q.size() == 0) begin
        $display("%0t: unexpected result kind %0d word %h", $time, m_axis_tuser,
                 m_axis_tdata[31:0]);
        errors++;
      end else begin
        exp_r = awaited_q.pop_front();
        if (m_axis_tuser !== exp_r.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, exp_r.kind, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[31:0] !== exp_r.word) begin
          $display("%0t: out_word expected %h actual %h", $time, exp_r.word,
                   m_axis_tdata[31:0]);
          errors++;
        end
        if (m_axis_tdata[38:32] !== exp_r.card) begin
          $display("%0t: card_address expected %0d actual %0d", $time, exp_r.card,
                   m_axis_tdata[38:32]);
          errors++;
        end
        if (m_axis_tlast !== exp_r.last) begin
          $display("%0t: last expected %b actual %b", $time, exp_r.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    lim_time = 0;
    lim_line = 0;
    card_at = 0;
    clear_job_image();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_instructions();
    test_faults();
    test_counter_overrun();
    test_full_rate();
    test_output_stall();
    test_random_jobs();
    settle_block();
    repeat (30) @(posedge clk_i);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/cme_pkg.sv
hdl/cme_dp.sv
hdl/cme_ctrl.sv
hdl/card_machine_executor_unit.sv
hdl/cme_checker.sv
verif/tb_top.sv
